### design/smrd_pkg.sv
// Shared types and constants for the shared-memory race detector.
// Holds the hash constants, the cell record layout and the race kind codes.
// No dependencies.
package smrd_pkg;

    localparam logic [63:0] HASH_K1 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_K2 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_K3 = 64'h94d049bb133111eb;

    localparam logic [10:0] NO_LANE = 11'h7FF;

    localparam logic [1:0] KIND_WAW = 2'd0;
    localparam logic [1:0] KIND_RAW = 2'd1;
    localparam logic [1:0] KIND_WAR = 2'd2;

    localparam logic [1:0] ROUND_LAST = 2'd2;

    typedef struct packed {
        logic [15:0] buffer;
        logic [31:0] offset;
        logic [31:0] epoch;
        logic [10:0] writer;
        logic [10:0] reader;
        logic        multi_read;
    } t_cell;

endpackage

### design/smrd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module smrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/smrd_hash.sv
// Iterative 64-bit mixing hash that yields the home slot of a cell.
// Uses one shared 32x32 multiplier over three rounds. Depends on smrd_pkg.
module smrd_hash #(
    parameter int SLOTS = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [15:0]              i_buf,
    input  logic [31:0]              i_off,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_slot
);
    import smrd_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_round;
    logic [1:0]  r_step;
    logic [15:0] r_buf;
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [63:0] r_p;
    logic [63:0] k;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod_sum;
    logic [63:0] t;
    logic [63:0] n_x;

    always_comb begin
        unique case (r_round)
            2'd0:    k = HASH_K1;
            2'd1:    k = HASH_K2;
            default: k = HASH_K3;
        endcase
        unique case (r_step)
            2'd0:    begin op_a = r_x[31:0];  op_b = k[31:0];  end
            2'd1:    begin op_a = r_x[31:0];  op_b = k[63:32]; end
            default: begin op_a = r_x[63:32]; op_b = k[31:0];  end
        endcase
        // Last partial product lands in the upper half of the running sum.
        prod_sum = r_acc + {r_p[31:0], 32'h0};
        unique case (r_round)
            2'd0: begin
                t   = prod_sum ^ {48'h0, r_buf};
                n_x = t ^ (t >> 30);
            end
            2'd1: begin
                t   = prod_sum;
                n_x = t ^ (t >> 27);
            end
            default: begin
                t   = prod_sum;
                n_x = t ^ (t >> 31);
                if (n_x == 64'h0) begin
                    n_x = 64'h1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p <= op_a * op_b;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_round <= 2'd0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_round <= 2'd0;
                r_step <= 2'd0;
                r_buf <= i_buf;
                r_x <= {32'h0, i_off};
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                unique case (r_step)
                    2'd0: ;
                    2'd1: r_acc <= r_p;
                    2'd2: r_acc[63:32] <= r_acc[63:32] + r_p[31:0];
                    default: begin
                        r_x <= n_x;
                        r_round <= r_round + 2'd1;
                        if (r_round == ROUND_LAST) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_slot = r_x[$clog2(SLOTS)-1:0];

endmodule

### design/smrd_cell_update.sv
// Epoch check and race classification for one shadow cell record.
// Pure combinational update of the record. Depends on smrd_pkg.
module smrd_cell_update (
    input  smrd_pkg::t_cell i_cell,
    input  logic [31:0]     i_epoch,
    input  logic            i_store,
    input  logic [9:0]      i_lane,
    output smrd_pkg::t_cell o_cell,
    output logic            o_race,
    output logic [1:0]      o_kind
);
    import smrd_pkg::*;

    t_cell       c;
    logic [10:0] lane_x;
    logic        other_writer;

    always_comb begin
        lane_x = {1'b0, i_lane};
        c = i_cell;
        // A cell from an older epoch starts clean.
        if (c.epoch != i_epoch) begin
            c.epoch = i_epoch;
            c.writer = NO_LANE;
            c.reader = NO_LANE;
            c.multi_read = 1'b0;
        end
        other_writer = (c.writer != NO_LANE) && (c.writer != lane_x);
        o_race = 1'b0;
        o_kind = KIND_WAW;
        if (i_store) begin
            if (other_writer) begin
                o_race = 1'b1;
                o_kind = KIND_WAW;
            end else if (((c.reader != NO_LANE) && (c.reader != lane_x)) || c.multi_read) begin
                o_race = 1'b1;
                o_kind = KIND_WAR;
            end
            c.writer = lane_x;
        end else begin
            if (other_writer) begin
                o_race = 1'b1;
                o_kind = KIND_RAW;
            end
            if (c.reader == NO_LANE) begin
                c.reader = lane_x;
            end else if (c.reader != lane_x) begin
                c.multi_read = 1'b1;
            end
        end
        o_cell = c;
    end

endmodule

### design/shared_memory_race_detector_core.sv
// Shared-memory race detector: hashed slot table plus shadow cell memory.
// Sequence: a barrier goes straight to the result load; an access runs the hash,
// then a slot read per probe step, plus a cell read for an occupied slot, then the load.
// Only one beat is in flight; the next is taken back in idle after the load, which waits
// while the output register is still full and not taken.
// Reset: synchronous, active low; then a sweep clears the slot table, no beat taken.
module shared_memory_race_detector_core #(
    parameter int MAX_CELLS = 4096,
    parameter int SLOTS     = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: cell_limit.
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    // Input beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: buffer_id[15:0], byte_offset[31:0], store flag,
    // lane[9:0], source_line[15:0], zero fill.
    input  logic [79:0] s_axis_tdata,
    // tuser: func (0 access, 1 barrier).
    input  logic        s_axis_tuser,
    // Result beats.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: race_found, race_kind[1:0], race_line[15:0],
    // race count so far[31:0], truncated, zero fill.
    output logic [55:0] m_axis_tdata
);
    import smrd_pkg::*;

    localparam int SB  = $clog2(SLOTS);
    localparam int CAW = $clog2(MAX_CELLS);
    localparam int CW  = $clog2(MAX_CELLS + 1);

    // The controller walks each access through hash, slot probe and cell
    // read-modify-write. Only one beat is in flight, so a cell write always
    // lands before the next read of that memory and no forwarding is needed.
    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_SLOT   = 7'b0001000,
        S_CELL   = 7'b0010000,
        S_RESULT = 7'b0100000,
        S_SPARE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [12:0]   r_cell_limit;
    logic [CW-1:0] r_count;
    logic [31:0]   r_epoch;
    logic [31:0]   r_total;
    logic          r_trunc;
    logic [SB-1:0] r_clr;
    logic [SB-1:0] r_slot;
    logic [CAW-1:0] r_cidx;

    logic [15:0] r_buf;
    logic [31:0] r_off;
    logic        r_wr;
    logic [9:0]  r_lane;
    logic [15:0] r_line;

    logic        r_res_found;
    logic [1:0]  r_res_kind;
    logic [15:0] r_res_line;

    logic        r_m_valid;
    logic [55:0] r_m_data;

    logic          accept;
    logic          hash_done;
    logic [SB-1:0] hash_slot;

    logic          slot_we;
    logic [SB-1:0] slot_waddr;
    logic [CW-1:0] slot_wdata;
    logic [SB-1:0] slot_raddr;
    logic [CW-1:0] slot_rdata;

    logic           cell_we;
    logic [CAW-1:0] cell_waddr;
    logic [CAW-1:0] cell_raddr;
    t_cell          cell_rdata;
    t_cell          fresh;
    t_cell          base;
    t_cell          upd_cell;
    logic           upd_race;
    logic [1:0]     upd_kind;

    logic [31:0] lim32;
    logic        full;
    logic        slot_empty;
    logic        cell_match;
    logic [CW-1:0] slot_minus1;
    logic        out_free;
    logic        finish;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free = !r_m_valid || m_axis_tready;

    // Limit in effect: zero means MAX_CELLS, and the table keeps one empty slot.
    always_comb begin
        lim32 = (r_cell_limit == 13'd0) ? 32'(MAX_CELLS) : {19'h0, r_cell_limit};
        if (lim32 > 32'(MAX_CELLS)) begin
            lim32 = 32'(MAX_CELLS);
        end
        if (lim32 > 32'(SLOTS - 1)) begin
            lim32 = 32'(SLOTS - 1);
        end
    end
    assign full = {{(32 - CW){1'b0}}, r_count} >= lim32;

    assign slot_empty  = (slot_rdata == '0);
    assign slot_minus1 = slot_rdata - CW'(1);
    assign cell_match  = (cell_rdata.buffer == r_buf) && (cell_rdata.offset == r_off);

    always_comb begin
        fresh.buffer = r_buf;
        fresh.offset = r_off;
        fresh.epoch = r_epoch;
        fresh.writer = NO_LANE;
        fresh.reader = NO_LANE;
        fresh.multi_read = 1'b0;
        base = (r_state == S_CELL) ? cell_rdata : fresh;
    end

    smrd_hash #(.SLOTS(SLOTS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && !s_axis_tuser),
        .i_buf   (s_axis_tdata[15:0]),
        .i_off   (s_axis_tdata[47:16]),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    smrd_cell_update u_update (
        .i_cell     (base),
        .i_epoch    (r_epoch),
        .i_store    (r_wr),
        .i_lane     (r_lane),
        .o_cell     (upd_cell),
        .o_race     (upd_race),
        .o_kind     (upd_kind)
    );

    // Slot and cell table port control: clearing sweep, new-cell insert, probe reads, cell write-back.
    always_comb begin
        slot_we = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = r_count + CW'(1);
        slot_raddr = r_slot;
        cell_we = 1'b0;
        cell_waddr = r_cidx;
        cell_raddr = slot_minus1[CAW-1:0];
        finish = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                slot_we = 1'b1;
                slot_waddr = r_clr;
                slot_wdata = '0;
            end
            S_HASH: begin
                slot_raddr = hash_slot;
            end
            S_SLOT: begin
                if (slot_empty) begin
                    finish = 1'b1;
                    if (!full) begin
                        slot_we = 1'b1;
                        cell_we = 1'b1;
                        cell_waddr = r_count[CAW-1:0];
                    end
                end
            end
            S_CELL: begin
                if (cell_match) begin
                    finish = 1'b1;
                    cell_we = 1'b1;
                end else begin
                    slot_raddr = r_slot + SB'(1);
                end
            end
            default: ;
        endcase
    end

    smrd_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    smrd_ram #(.WIDTH($bits(t_cell)), .DEPTH(MAX_CELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (upd_cell),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    n_state = s_axis_tuser ? S_RESULT : S_HASH;
                end
            end
            S_HASH:   if (hash_done) n_state = S_SLOT;
            S_SLOT:   n_state = slot_empty ? S_RESULT : S_CELL;
            S_CELL:   n_state = cell_match ? S_RESULT : S_SLOT;
            S_RESULT: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf  <= s_axis_tdata[15:0];
            r_off  <= s_axis_tdata[47:16];
            r_wr   <= s_axis_tdata[48];
            r_lane <= s_axis_tdata[58:49];
            r_line <= s_axis_tdata[74:59];
            r_res_found <= 1'b0;
            r_res_kind <= KIND_WAW;
            r_res_line <= 16'h0;
        end
        if (r_state == S_HASH) begin
            r_slot <= hash_slot;
        end
        if (r_state == S_SLOT) begin
            r_cidx <= slot_minus1[CAW-1:0];
        end
        if (r_state == S_CELL && !cell_match) begin
            r_slot <= r_slot + SB'(1);
        end
        if (finish && !(r_state == S_SLOT && full)) begin
            r_res_found <= upd_race;
            r_res_kind <= upd_race ? upd_kind : KIND_WAW;
            r_res_line <= upd_race ? r_line : 16'h0;
        end
        if (r_state == S_RESULT && out_free) begin
            r_m_data <= {4'h0, r_trunc, r_total, r_res_line, r_res_kind, r_res_found};
        end

        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cell_limit <= 13'd4096;
            r_count <= '0;
            r_epoch <= 32'h0;
            r_total <= 32'h0;
            r_trunc <= 1'b0;
            r_clr <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cell_limit <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SB'(1);
            end
            if (accept && s_axis_tuser) begin
                r_epoch <= r_epoch + 32'h1;
            end
            if (r_state == S_SLOT && slot_empty) begin
                if (full) begin
                    r_trunc <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (finish && upd_race && !(r_state == S_SLOT && full) && r_total != '1) begin
                r_total <= r_total + 32'h1;
            end
            if (r_state == S_RESULT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
